@@ design/rdi_pkg.sv @@
`timescale 1ns / 1ps
package rdi_pkg;

  localparam int QUEUE_DEPTH = 4;
  // magnitude widths of n.dir and of n.center - n.origin
  localparam int DW = 52;
  localparam int NW = 53;
  // quotient bits (Q15.16) and partial remainder width
  localparam int QW = 31;
  localparam int RW = 53;
  localparam int PW = 50;

  typedef enum logic [2:0] {
    REG_RADIUS_SQ = 3'd0,
    REG_CENTER_X  = 3'd1,
    REG_CENTER_Y  = 3'd2,
    REG_CENTER_Z  = 3'd3,
    REG_NORMAL_X  = 3'd4,
    REG_NORMAL_Y  = 3'd5,
    REG_NORMAL_Z  = 3'd6,
    REG_EPSILON   = 3'd7
  } reg_idx_t;

  // origin_x, the last field declared, in the lowest bits
  typedef struct packed {
    logic [31:0] max_dist;
    logic [31:0] min_dist;
    logic [31:0] dir_z;
    logic [31:0] dir_y;
    logic [31:0] dir_x;
    logic [31:0] origin_z;
    logic [31:0] origin_y;
    logic [31:0] origin_x;
  } ray_t;

  typedef struct packed {
    logic [17:0] normal_x;
    logic [17:0] normal_y;
    logic [17:0] normal_z;
    logic [15:0] edge_epsilon;
    logic [31:0] center_x;
    logic [31:0] center_y;
    logic [31:0] center_z;
  } front_cfg_t;

  typedef struct packed {
    logic [31:0] radius_squared;
    logic [31:0] center_x;
    logic [31:0] center_y;
    logic [31:0] center_z;
  } back_cfg_t;

  typedef struct packed {
    logic          miss;
    logic          neg;
    logic [DW-1:0] aden;
    logic [NW-1:0] anum;
    ray_t          ray;
  } item_t;

  typedef struct packed {
    logic          miss;
    logic          neg;
    logic [DW-1:0] aden;
    logic [RW-1:0] rem;
    logic [QW-1:0] sh;
    logic [QW-1:0] q;
    ray_t          ray;
  } div_t;

endpackage

@@ design/ray_disc_intersect_unit.sv @@
`timescale 1ns / 1ps
// channel   direction  handshake               payload
// s_*       in         s_tvalid / s_tready     s_tdata: one ray (8 x Q16.16)
// m_*       out        m_tvalid / m_tready     m_tdata: hit flag, hit distance
// cfg_*     in         cfg_we                  cfg_addr, cfg_wdata
//
// One ray per cycle while the output is taken; an output transfer follows its
// input transfer through 3 front stages, the queue, a load stage and 31 divider
// stages of one quotient bit each, then 6 hit-test stages.
// Synchronous reset empties the pipeline and loads the register defaults.
// The front stalls only when the queue is full; the back stalls only while
// the output register holds a result that has not been taken.
module ray_disc_intersect_unit #(
  parameter int QUEUE_DEPTH = rdi_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, min_dist, max_dist
  input  logic [255:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // hit, hit_dist, 7 bits zero
  output logic [39:0]  m_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata
);

  logic [31:0] radius_squared;
  logic [31:0] center_x, center_y, center_z;
  logic [17:0] normal_x, normal_y, normal_z;
  logic [15:0] edge_epsilon;

  rdi_pkg::front_cfg_t fcfg;
  rdi_pkg::back_cfg_t  bcfg;
  rdi_pkg::item_t      f_item, q_item;
  logic push, full, pop, nonempty;
  logic hit;
  logic [31:0] hit_dist;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_squared <= 32'h0001_0000;
      center_x       <= '0;
      center_y       <= '0;
      center_z       <= '0;
      normal_x       <= '0;
      normal_y       <= '0;
      normal_z       <= 18'h1_0000;
      edge_epsilon   <= 16'h0001;
    end else if (cfg_we) begin
      unique case (rdi_pkg::reg_idx_t'(cfg_addr))
        rdi_pkg::REG_RADIUS_SQ: radius_squared <= cfg_wdata;
        rdi_pkg::REG_CENTER_X:  center_x       <= cfg_wdata;
        rdi_pkg::REG_CENTER_Y:  center_y       <= cfg_wdata;
        rdi_pkg::REG_CENTER_Z:  center_z       <= cfg_wdata;
        rdi_pkg::REG_NORMAL_X:  normal_x       <= cfg_wdata[17:0];
        rdi_pkg::REG_NORMAL_Y:  normal_y       <= cfg_wdata[17:0];
        rdi_pkg::REG_NORMAL_Z:  normal_z       <= cfg_wdata[17:0];
        rdi_pkg::REG_EPSILON:   edge_epsilon   <= cfg_wdata[15:0];
        default:                ;
      endcase
    end
  end

  assign fcfg = '{normal_x: normal_x, normal_y: normal_y, normal_z: normal_z,
                  edge_epsilon: edge_epsilon, center_x: center_x,
                  center_y: center_y, center_z: center_z};
  assign bcfg = '{radius_squared: radius_squared, center_x: center_x,
                  center_y: center_y, center_z: center_z};

  rdi_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_ray   (rdi_pkg::ray_t'(s_tdata)),
    .cfg      (fcfg),
    .push     (push),
    .item     (f_item),
    .full     (full)
  );

  rdi_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    (f_item),
    .full     (full),
    .pop      (pop),
    .nonempty (nonempty),
    .rdata    (q_item)
  );

  rdi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (nonempty),
    .q_item    (q_item),
    .q_pop     (pop),
    .cfg       (bcfg),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .hit       (hit),
    .hit_dist  (hit_dist)
  );

  assign m_tdata = {7'b0, hit_dist, hit};

endmodule

@@ design/rdi_front.sv @@
`timescale 1ns / 1ps
module rdi_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rdi_pkg::ray_t      in_ray,
  input  rdi_pkg::front_cfg_t cfg,
  output logic               push,
  output rdi_pkg::item_t     item,
  input  logic               full
);

  logic en;
  logic v1, v2, v3;
  rdi_pkg::ray_t ray1, ray2;
  logic signed [rdi_pkg::PW-1:0] pd [3];
  logic signed [rdi_pkg::PW-1:0] pc [3];
  logic signed [rdi_pkg::PW-1:0] po [3];
  logic signed [rdi_pkg::DW-1:0] den;
  logic signed [rdi_pkg::NW-1:0] num;
  logic [rdi_pkg::DW-1:0] aden;
  logic [rdi_pkg::NW-1:0] anum;

  assign en       = !v3 || !full;
  assign in_ready = en;
  assign push     = v3 && !full;

  assign aden = den[rdi_pkg::DW-1] ? rdi_pkg::DW'(-den) : rdi_pkg::DW'(den);
  assign anum = num[rdi_pkg::NW-1] ? rdi_pkg::NW'(-num) : rdi_pkg::NW'(num);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ray1  <= in_ray;
      pd[0] <= $signed(cfg.normal_x) * $signed(in_ray.dir_x);
      pd[1] <= $signed(cfg.normal_y) * $signed(in_ray.dir_y);
      pd[2] <= $signed(cfg.normal_z) * $signed(in_ray.dir_z);
      pc[0] <= $signed(cfg.normal_x) * $signed(cfg.center_x);
      pc[1] <= $signed(cfg.normal_y) * $signed(cfg.center_y);
      pc[2] <= $signed(cfg.normal_z) * $signed(cfg.center_z);
      po[0] <= $signed(cfg.normal_x) * $signed(in_ray.origin_x);
      po[1] <= $signed(cfg.normal_y) * $signed(in_ray.origin_y);
      po[2] <= $signed(cfg.normal_z) * $signed(in_ray.origin_z);

      ray2 <= ray1;
      den  <= rdi_pkg::DW'(pd[0]) + rdi_pkg::DW'(pd[1]) + rdi_pkg::DW'(pd[2]);
      num  <= rdi_pkg::NW'(pc[0]) + rdi_pkg::NW'(pc[1]) + rdi_pkg::NW'(pc[2])
            - rdi_pkg::NW'(po[0]) - rdi_pkg::NW'(po[1]) - rdi_pkg::NW'(po[2]);

      // grazing rays and a zero denominator are marked as a miss here
      item.miss <= (den == '0) || (aden < rdi_pkg::DW'({cfg.edge_epsilon, 16'h0000}));
      item.neg  <= num[rdi_pkg::NW-1] ^ den[rdi_pkg::DW-1];
      item.aden <= aden;
      item.anum <= anum;
      item.ray  <= ray2;
    end
  end

endmodule

@@ design/rdi_queue.sv @@
`timescale 1ns / 1ps
module rdi_queue #(
  parameter int DEPTH = rdi_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rdi_pkg::item_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           nonempty,
  output rdi_pkg::item_t rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rdi_pkg::item_t mem [DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(DEPTH));
  assign nonempty = (count != '0);
  assign rdata    = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ design/rdi_back.sv @@
`timescale 1ns / 1ps
module rdi_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  rdi_pkg::item_t     q_item,
  output logic               q_pop,
  input  rdi_pkg::back_cfg_t cfg,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               hit,
  output logic [31:0]        hit_dist
);

  localparam int QW = rdi_pkg::QW;
  localparam int RW = rdi_pkg::RW;

  logic en;
  logic       dv [QW+1];
  rdi_pkg::div_t ds [QW+1];
  logic [RW-1:0] rem0;

  logic vt, vm, vh, va, vs;
  logic mt, mm, mh, ma, ms;
  logic signed [31:0] tt, tm, th, ta, ts;
  rdi_pkg::ray_t rt, rm;
  logic [31:0] maxh, maxa, maxs;
  logic signed [63:0] p [3];
  logic signed [rdi_pkg::PW-1:0] diff [3];
  logic [rdi_pkg::PW-1:0] amag [3];
  logic [23:0] a [3];
  logic [47:0] sq [3];
  logic [rdi_pkg::PW-1:0] sum;
  logic near;

  assign en    = !out_valid || out_ready;
  assign q_pop = en && q_valid;
  assign rem0  = RW'(q_item.anum >> 15);

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= q_valid;
    end
  end

  // an integer part of 2^15 or more would overflow and is a miss
  always_ff @(posedge clk) begin
    if (en) begin
      ds[0].miss <= q_item.miss || (rem0 >= RW'(q_item.aden));
      ds[0].neg  <= q_item.neg;
      ds[0].aden <= q_item.aden;
      ds[0].rem  <= rem0;
      ds[0].sh   <= {q_item.anum[14:0], 16'h0000};
      ds[0].q    <= '0;
      ds[0].ray  <= q_item.ray;
    end
  end

  // one quotient bit per stage, restoring
  for (genvar k = 1; k <= QW; k++) begin : g_div
    logic [RW-1:0] trial;
    logic          ge;
    assign trial = {ds[k-1].rem[RW-2:0], ds[k-1].sh[QW-1]};
    assign ge    = trial >= RW'(ds[k-1].aden);

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k] <= 1'b0;
      end else if (en) begin
        dv[k] <= dv[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ds[k].miss <= ds[k-1].miss;
        ds[k].neg  <= ds[k-1].neg;
        ds[k].aden <= ds[k-1].aden;
        ds[k].rem  <= ge ? trial - RW'(ds[k-1].aden) : trial;
        ds[k].sh   <= ds[k-1].sh << 1;
        ds[k].q    <= {ds[k-1].q[QW-2:0], ge};
        ds[k].ray  <= ds[k-1].ray;
      end
    end
  end

  always_comb begin
    sum  = rdi_pkg::PW'(sq[0]) + rdi_pkg::PW'(sq[1]) + rdi_pkg::PW'(sq[2]);
    near = sum <= rdi_pkg::PW'({cfg.radius_squared, 16'h0000});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vt        <= 1'b0;
      vm        <= 1'b0;
      vh        <= 1'b0;
      va        <= 1'b0;
      vs        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vt        <= dv[QW];
      vm        <= vt;
      vh        <= vm;
      va        <= vh;
      vs        <= va;
      out_valid <= vs;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // apply the sign to the truncated magnitude
      mt <= ds[QW].miss;
      rt <= ds[QW].ray;
      tt <= ds[QW].neg ? -$signed({1'b0, ds[QW].q}) : $signed({1'b0, ds[QW].q});

      mm   <= mt || (tt < $signed(rt.min_dist)) || (tt > $signed(rt.max_dist));
      tm   <= tt;
      rm   <= rt;
      p[0] <= tt * $signed(rt.dir_x);
      p[1] <= tt * $signed(rt.dir_y);
      p[2] <= tt * $signed(rt.dir_z);

      // floor each product to Q16.16, then offset from the centre
      mh      <= mm;
      th      <= tm;
      maxh    <= rm.max_dist;
      diff[0] <= rdi_pkg::PW'($signed(rm.origin_x)) + rdi_pkg::PW'(p[0] >>> 16)
               - rdi_pkg::PW'($signed(cfg.center_x));
      diff[1] <= rdi_pkg::PW'($signed(rm.origin_y)) + rdi_pkg::PW'(p[1] >>> 16)
               - rdi_pkg::PW'($signed(cfg.center_y));
      diff[2] <= rdi_pkg::PW'($signed(rm.origin_z)) + rdi_pkg::PW'(p[2] >>> 16)
               - rdi_pkg::PW'($signed(cfg.center_z));

      ma   <= mh || (amag[0][rdi_pkg::PW-1:24] != '0) || (amag[1][rdi_pkg::PW-1:24] != '0)
            || (amag[2][rdi_pkg::PW-1:24] != '0);
      ta   <= th;
      maxa <= maxh;
      a[0] <= amag[0][23:0];
      a[1] <= amag[1][23:0];
      a[2] <= amag[2][23:0];

      ms    <= ma;
      ts    <= ta;
      maxs  <= maxa;
      sq[0] <= a[0] * a[0];
      sq[1] <= a[1] * a[1];
      sq[2] <= a[2] * a[2];

      hit      <= !ms && near;
      hit_dist <= (!ms && near) ? ts : maxs;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_mag
    assign amag[i] = diff[i][rdi_pkg::PW-1] ? rdi_pkg::PW'(-diff[i]) : rdi_pkg::PW'(diff[i]);
  end

endmodule
